// ===== design/sthl_pkg.sv =====
// shared types and constants for the segment table height lookup
// no dependencies; imported by every module of the block
package sthl_pkg;

  // coordinate width, signed fixed point with 8 fraction bits
  localparam int COORD_W = 24;
  // one stored segment: {left_x, left_y, right_x, right_y}
  localparam int SEG_W = 4 * COORD_W;
  // default table depth
  localparam int SEG_DEPTH_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic signed [COORD_W-1:0] query_x;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic                      found;
    logic signed [COORD_W-1:0] height;
    logic                      table_full;
  } out_item_t;

  // request to the multiply/divide unit: quo = mag * off / run
  typedef struct packed {
    logic               start;
    logic [COORD_W:0]   mag;
    logic [COORD_W-1:0] off;
    logic [COORD_W-1:0] run;
  } md_req_t;

  // response from the multiply/divide unit
  typedef struct packed {
    logic             done;
    logic [COORD_W:0] quo;
  } md_rsp_t;

endpackage

// ===== design/sthl_seg_mem.sv =====
// segment storage: one write port, one read port with registered data
// depends on sthl_pkg for the entry width
module sthl_seg_mem #(
  parameter int DEPTH = sthl_pkg::SEG_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [sthl_pkg::SEG_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [sthl_pkg::SEG_W-1:0] rd_data
);
  import sthl_pkg::*;

  logic [SEG_W-1:0] mem [DEPTH];
  logic [SEG_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered: data appears in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sthl_muldiv.sv =====
// shared iterative unit: shift-add multiply, then restoring divide
// one adder/subtractor used in both phases; depends on sthl_pkg
module sthl_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  sthl_pkg::md_req_t req,
  output sthl_pkg::md_rsp_t rsp
);
  import sthl_pkg::*;

  localparam int CNT_W = $clog2(COORD_W + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_PACK = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]         phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [COORD_W:0]   acc_r, acc_nxt;
  logic [COORD_W:0]   sh_r, sh_nxt;
  logic [COORD_W:0]   mag_r, mag_nxt;
  logic [COORD_W-1:0] run_r, run_nxt;

  logic [COORD_W+1:0] op_a, op_b, sum;
  logic               sub;
  logic [COORD_W:0]   div_try;
  logic               ge;

  // shared adder operand selection
  always_comb begin
    div_try = {acc_r[COORD_W-1:0], sh_r[COORD_W]};
    if (phase_r == PH_DIV) begin
      op_a = {1'b0, div_try};
      op_b = {2'b00, run_r};
      sub  = 1'b1;
    end else begin
      op_a = {1'b0, acc_r};
      op_b = sh_r[0] ? {1'b0, mag_r} : '0;
      sub  = 1'b0;
    end
    sum = op_a + (sub ? ~op_b : op_b) + {{(COORD_W+1){1'b0}}, sub};
    ge  = ~sum[COORD_W+1];
  end

  // sequencer
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    mag_nxt   = mag_r;
    run_nxt   = run_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          sh_nxt    = {1'b0, req.off};
          mag_nxt   = req.mag;
          run_nxt   = req.run;
          cnt_nxt   = '0;
          phase_nxt = PH_MUL;
        end
      end
      PH_MUL: begin
        // add the multiplicand when the low bit is set, shift right
        acc_nxt = sum[COORD_W+1:1];
        sh_nxt  = {sum[0], sh_r[COORD_W:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          phase_nxt = PH_PACK;
        end
      end
      PH_PACK: begin
        // product is {acc, sh[hi:1]}; top bits become the partial remainder
        acc_nxt   = {1'b0, acc_r[COORD_W:1]};
        sh_nxt    = {acc_r[0], sh_r[COORD_W:1]};
        cnt_nxt   = '0;
        phase_nxt = PH_DIV;
      end
      PH_DIV: begin
        // one quotient bit a step
        acc_nxt = ge ? sum[COORD_W:0] : div_try;
        sh_nxt  = {sh_r[COORD_W-1:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W)) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mag_r <= mag_nxt;
    run_r <= run_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sh_r;

endmodule

// ===== design/segment_table_height_lookup_top.sv =====
// segment table height lookup: command decode, table scan and sequencer
// depends on sthl_pkg, sthl_seg_mem and sthl_muldiv
//
// usage
//   a command beat is taken when start is high and busy is low; every beat
//   gives exactly one result, shown on out_item for one cycle with out_valid
//   clear and insert answer in the cycle after the beat and never raise busy
//   a query reads the table one entry a cycle through the memory read port,
//   keeping the last segment that spans query_x, then runs the shared
//   multiply/divide unit: COORD_W steps of multiply, one repack step and
//   COORD_W+1 steps of divide
//   a query to an empty table answers in the cycle after the beat and does
//   not raise busy
//   a query that hits no segment answers right after the scan
//   busy stays high from query acceptance until its result is shown; the next
//   beat may be taken in the cycle the result is on the ports
//   the receiver cannot stall: results are never held back
//   reset empties the table (count to zero) and returns to idle; table
//   contents are not cleared
module segment_table_height_lookup_top #(
  parameter int MAX_SEGMENTS = sthl_pkg::SEG_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sthl_pkg::in_item_t  in_item,
  output logic                out_valid,
  output sthl_pkg::out_item_t out_item
);
  import sthl_pkg::*;

  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            issue_r, issue_nxt;
  logic            pend_r, pend_nxt;
  logic            last_r, last_nxt;
  logic            hit_r, hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic signed [COORD_W-1:0] qx_r, qx_nxt;
  logic signed [COORD_W-1:0] h_x1_r, h_x1_nxt;
  logic signed [COORD_W-1:0] h_y1_r, h_y1_nxt;
  logic signed [COORD_W-1:0] h_x2_r, h_x2_nxt;
  logic signed [COORD_W-1:0] h_y2_r, h_y2_nxt;
  logic                      neg_r, neg_nxt;

  logic             accept, full, wr_en;
  logic [SEG_W-1:0] wr_data, rd_data;
  logic signed [COORD_W-1:0] rd_lx, rd_ly, rd_rx, rd_ry;
  logic             match;
  logic signed [COORD_W:0]   rise;
  logic [COORD_W:0]          rise_mag;
  logic [COORD_W-1:0]        run, off;
  logic signed [COORD_W+1:0] y1_ext, quo_ext, res;
  logic signed [COORD_W-1:0] res_sat;
  md_req_t          md_req;
  md_rsp_t          md_rsp;

  assign accept = start && !busy;
  assign full   = (count_r == CNTW'(MAX_SEGMENTS));
  assign wr_en  = accept && (in_item.command == CMD_INSERT) && !full;
  assign wr_data = {in_item.left_x, in_item.left_y, in_item.right_x, in_item.right_y};

  sthl_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // fields of the entry read last cycle
  assign rd_lx = $signed(rd_data[4*COORD_W-1:3*COORD_W]);
  assign rd_ly = $signed(rd_data[3*COORD_W-1:2*COORD_W]);
  assign rd_rx = $signed(rd_data[2*COORD_W-1:COORD_W]);
  assign rd_ry = $signed(rd_data[COORD_W-1:0]);
  assign match = (qx_r >= rd_lx) && (qx_r < rd_rx);

  // segment slope terms for the multiply/divide unit
  always_comb begin
    rise     = $signed({h_y2_r[COORD_W-1], h_y2_r}) - $signed({h_y1_r[COORD_W-1], h_y1_r});
    rise_mag = rise[COORD_W] ? -rise : rise;
    run      = h_x2_r - h_x1_r;
    off      = qx_r - h_x1_r;
    md_req.start = (state_r == ST_SETUP);
    md_req.mag   = rise_mag;
    md_req.off   = off;
    md_req.run   = run;
  end

  sthl_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // final offset from y1 with a saturation guard
  always_comb begin
    y1_ext  = {h_y1_r[COORD_W-1], h_y1_r[COORD_W-1], h_y1_r};
    quo_ext = $signed({1'b0, md_rsp.quo});
    res     = neg_r ? y1_ext - quo_ext : y1_ext + quo_ext;
    if ((res[COORD_W+1:COORD_W-1] != 3'b000) && (res[COORD_W+1:COORD_W-1] != 3'b111)) begin
      res_sat = res[COORD_W+1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res_sat = res[COORD_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    qx_nxt        = qx_r;
    h_x1_nxt      = h_x1_r;
    h_y1_nxt      = h_y1_r;
    h_x2_nxt      = h_x2_r;
    h_y2_nxt      = h_y2_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_item_nxt = '0;
          unique case (in_item.command)
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_item_nxt.table_full = 1'b1;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              qx_nxt = in_item.query_x;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                issue_nxt = 1'b1;
                pend_nxt  = 1'b0;
                hit_nxt   = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // issue one read a cycle
        pend_nxt = issue_r;
        if (issue_r) begin
          last_nxt = (CNTW'(idx_r) == count_r - 1'b1);
          if (CNTW'(idx_r) == count_r - 1'b1) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // check the entry read last cycle, later hits replace earlier ones
        if (pend_r) begin
          if (match) begin
            hit_nxt  = 1'b1;
            h_x1_nxt = rd_lx;
            h_y1_nxt = rd_ly;
            h_x2_nxt = rd_rx;
            h_y2_nxt = rd_ry;
          end
          if (last_r) begin
            if (hit_r || match) begin
              state_nxt = ST_SETUP;
            end else begin
              out_item_nxt  = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
        end
      end
      ST_SETUP: begin
        neg_nxt   = rise[COORD_W];
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          out_item_nxt        = '0;
          out_item_nxt.found  = 1'b1;
          out_item_nxt.height = res_sat;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    hit_r      <= hit_nxt;
    qx_r       <= qx_nxt;
    h_x1_r     <= h_x1_nxt;
    h_y1_r     <= h_y1_nxt;
    h_x2_r     <= h_x2_nxt;
    h_y2_r     <= h_y2_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
